// File: rtl/mi3_pkg.sv
// Shared constants and index tables for the 3x3 matrix inverse core.
// No dependencies; imported by every module of the core.
package mi3_pkg;

	localparam int ELEMENT_BITS_DEF = 16;
	localparam int FRAC_SHIFT = 24;
	localparam int DIV_STEPS = 33;
	localparam int FRONT_STAGES = 5;
	localparam int INV_W = 32;
	localparam int DET_W = 50;
	localparam int NUM_LANES = 9;

	typedef logic [3:0] idx_t;

	// adj[i] = m[a] * m[b] - m[c] * m[d]
	localparam idx_t COF_IDX [NUM_LANES][4] = '{
		'{idx_t'(4), idx_t'(8), idx_t'(7), idx_t'(5)},
		'{idx_t'(2), idx_t'(7), idx_t'(1), idx_t'(8)},
		'{idx_t'(1), idx_t'(5), idx_t'(4), idx_t'(2)},
		'{idx_t'(6), idx_t'(5), idx_t'(3), idx_t'(8)},
		'{idx_t'(0), idx_t'(8), idx_t'(6), idx_t'(2)},
		'{idx_t'(2), idx_t'(3), idx_t'(0), idx_t'(5)},
		'{idx_t'(3), idx_t'(7), idx_t'(6), idx_t'(4)},
		'{idx_t'(6), idx_t'(1), idx_t'(0), idx_t'(7)},
		'{idx_t'(0), idx_t'(4), idx_t'(3), idx_t'(1)}
	};

endpackage

// File: rtl/mi3_front.sv
// Front end: cofactor products, adjugate, determinant, magnitudes and signs.
// Five pipeline stages; depends on mi3_pkg.
module mi3_front import mi3_pkg::*; #(
	parameter int EW = ELEMENT_BITS_DEF,
	localparam int AW = 2 * EW + 1,
	localparam int DW = 3 * EW + 3,
	localparam int PW = 3 * EW + 1
) (
	input  logic                 clk,
	input  logic [FRONT_STAGES-1:0] en,
	input  logic signed [EW-1:0] m [NUM_LANES],
	output logic [AW-1:0]        adj_mag [NUM_LANES],
	output logic [NUM_LANES-1:0] neg,
	output logic [DW-1:0]        det_mag,
	output logic signed [DW-1:0] det,
	output logic                 singular
);

	logic signed [2*EW-1:0] pa_s1 [NUM_LANES];
	logic signed [2*EW-1:0] pb_s1 [NUM_LANES];
	logic signed [EW-1:0]   mr_s1 [3];
	logic signed [AW-1:0]   adj_s2 [NUM_LANES];
	logic signed [EW-1:0]   mr_s2 [3];
	logic signed [AW-1:0]   adj_s3 [NUM_LANES];
	logic signed [PW-1:0]   dp_s3 [3];
	logic signed [AW-1:0]   adj_s4 [NUM_LANES];
	logic signed [DW-1:0]   det_s4;
	logic [AW-1:0]          mag_s5 [NUM_LANES];
	logic [NUM_LANES-1:0]   neg_s5;
	logic [DW-1:0]          dmag_s5;
	logic signed [DW-1:0]   det_s5;
	logic                   sing_s5;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				pa_s1[i] <= m[COF_IDX[i][0]] * m[COF_IDX[i][1]];
				pb_s1[i] <= m[COF_IDX[i][2]] * m[COF_IDX[i][3]];
			end
			for (int j = 0; j < 3; j++) mr_s1[j] <= m[j];
		end
		if (en[1]) begin
			for (int i = 0; i < NUM_LANES; i++) adj_s2[i] <= AW'(pa_s1[i]) - AW'(pb_s1[i]);
			mr_s2 <= mr_s1;
		end
		if (en[2]) begin
			for (int j = 0; j < 3; j++) dp_s3[j] <= mr_s2[j] * adj_s2[3*j];
			adj_s3 <= adj_s2;
		end
		if (en[3]) begin
			det_s4 <= DW'(dp_s3[0]) + DW'(dp_s3[1]) + DW'(dp_s3[2]);
			adj_s4 <= adj_s3;
		end
		if (en[4]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				mag_s5[i] <= adj_s4[i][AW-1] ? AW'(-adj_s4[i]) : AW'(adj_s4[i]);
				neg_s5[i] <= adj_s4[i][AW-1] ^ det_s4[DW-1];
			end
			dmag_s5 <= det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);
			det_s5 <= det_s4;
			sing_s5 <= (det_s4 == '0);
		end
	end

	assign adj_mag = mag_s5;
	assign neg = neg_s5;
	assign det_mag = dmag_s5;
	assign det = det_s5;
	assign singular = sing_s5;

endmodule

// File: rtl/mi3_div_lane.sv
// One divider lane: restoring division, one quotient bit per pipeline stage.
// Depends on mi3_pkg.
module mi3_div_lane import mi3_pkg::*; #(
	parameter int NW = 57,
	parameter int DW = 51,
	localparam int CW = DW + DIV_STEPS + 1
) (
	input  logic                 clk,
	input  logic [DIV_STEPS-1:0] en,
	input  logic [NW-1:0]        num,
	input  logic [DW-1:0]        den,
	output logic [DIV_STEPS-1:0] quo
);

	logic [NW-1:0]        rem_s [DIV_STEPS+1];
	logic [DW-1:0]        den_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS+1];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - k;
		logic [CW-1:0] rx, dx;
		logic ge;
		always_comb begin
			rx = CW'(rem_s[k]);
			dx = CW'(den_s[k]) << SH;
			ge = (rx >= dx);
		end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k+1] <= ge ? NW'(rx - dx) : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][DIV_STEPS-2:0], ge};
			end
		end
	end

	assign quo = quo_s[DIV_STEPS];

endmodule

// File: rtl/mi3_merge.sv
// Merge stage: sign, saturation and singular masking of the nine lane quotients.
// Output register of the core; depends on mi3_pkg.
module mi3_merge import mi3_pkg::*; #(
	parameter int DW = 51
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DIV_STEPS-1:0] quo [NUM_LANES],
	input  logic [NUM_LANES-1:0] neg,
	input  logic signed [DW-1:0] det,
	input  logic                 singular,
	output logic [INV_W-1:0]     inv [NUM_LANES],
	output logic [DET_W-1:0]     determinant,
	output logic                 singular_out
);

	localparam logic [DIV_STEPS-1:0] NEG_LIM = DIV_STEPS'(33'h080000000);
	localparam logic [DIV_STEPS-1:0] POS_LIM = DIV_STEPS'(33'h07FFFFFFF);

	logic [INV_W-1:0] inv_q [NUM_LANES];
	logic [DET_W-1:0] det_q;
	logic             sing_q;
	logic signed [DW+DET_W-1:0] det_x;

	assign det_x = {{DET_W{det[DW-1]}}, det};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				if (singular)
					inv_q[i] <= '0;
				else if (neg[i])
					inv_q[i] <= (quo[i] > NEG_LIM) ? 32'h80000000 : INV_W'(-quo[i]);
				else
					inv_q[i] <= (quo[i] > POS_LIM) ? 32'h7FFFFFFF : INV_W'(quo[i]);
			end
			det_q <= singular ? '0 : det_x[DET_W-1:0];
			sing_q <= singular;
		end
	end

	assign inv = inv_q;
	assign determinant = det_q;
	assign singular_out = sing_q;

endmodule

// File: rtl/matrix3x3_inverse_core.sv
// 3x3 matrix inverse by adjugate over determinant, Q8.8 in, Q16.16 out.
// Pipeline: 5 front stages, 33 divider steps, 1 merge stage.
// Throughput: one matrix per cycle while result_ready is high; nine divider lanes, one quotient bit per stage.
// Each stage holds its word only while the next is full and stalled.
// Reset (arst_n low) clears all stage valid bits; data registers keep no reset.
module matrix3x3_inverse_core import mi3_pkg::*; #(
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [ELEMENT_BITS-1:0] a00,
	input  logic signed [ELEMENT_BITS-1:0] a01,
	input  logic signed [ELEMENT_BITS-1:0] a02,
	input  logic signed [ELEMENT_BITS-1:0] a10,
	input  logic signed [ELEMENT_BITS-1:0] a11,
	input  logic signed [ELEMENT_BITS-1:0] a12,
	input  logic signed [ELEMENT_BITS-1:0] a20,
	input  logic signed [ELEMENT_BITS-1:0] a21,
	input  logic signed [ELEMENT_BITS-1:0] a22,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [INV_W-1:0]       inv00,
	output logic signed [INV_W-1:0]       inv01,
	output logic signed [INV_W-1:0]       inv02,
	output logic signed [INV_W-1:0]       inv10,
	output logic signed [INV_W-1:0]       inv11,
	output logic signed [INV_W-1:0]       inv12,
	output logic signed [INV_W-1:0]       inv20,
	output logic signed [INV_W-1:0]       inv21,
	output logic signed [INV_W-1:0]       inv22,
	output logic signed [DET_W-1:0]       determinant,
	output logic                          singular
);

	localparam int AW = 2 * ELEMENT_BITS + 1;
	localparam int DW = 3 * ELEMENT_BITS + 3;
	localparam int NW = AW + FRAC_SHIFT;
	localparam int NS = FRONT_STAGES + DIV_STEPS + 1;

	logic [NS-1:0] vld_q;
	logic [NS:0]   en;

	logic signed [ELEMENT_BITS-1:0] m [NUM_LANES];
	logic [AW-1:0]          adj_mag [NUM_LANES];
	logic [NUM_LANES-1:0]   neg_f;
	logic [DW-1:0]          det_mag;
	logic signed [DW-1:0]   det_f;
	logic                   sing_f;
	logic [DIV_STEPS-1:0]   quo [NUM_LANES];
	logic [INV_W-1:0]       inv [NUM_LANES];

	logic [NUM_LANES-1:0]   neg_s [DIV_STEPS+1];
	logic signed [DW-1:0]   det_s [DIV_STEPS+1];
	logic                   sing_s [DIV_STEPS+1];

	assign m = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

	// advance a stage when it is empty or the stage after it advances
	assign en[NS] = result_ready;
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = ~vld_q[k] | en[k+1];
	end
	assign item_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= item_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	mi3_front #(.EW(ELEMENT_BITS)) u_front (
		.clk      (clk),
		.en       (en[FRONT_STAGES-1:0]),
		.m        (m),
		.adj_mag  (adj_mag),
		.neg      (neg_f),
		.det_mag  (det_mag),
		.det      (det_f),
		.singular (sing_f)
	);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		mi3_div_lane #(.NW(NW), .DW(DW)) u_lane (
			.clk (clk),
			.en  (en[FRONT_STAGES+DIV_STEPS-1:FRONT_STAGES]),
			.num ({adj_mag[i], {FRAC_SHIFT{1'b0}}}),
			.den (det_mag),
			.quo (quo[i])
		);
	end

	assign neg_s[0] = neg_f;
	assign det_s[0] = det_f;
	assign sing_s[0] = sing_f;
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[FRONT_STAGES+k]) begin
				neg_s[k+1] <= neg_s[k];
				det_s[k+1] <= det_s[k];
				sing_s[k+1] <= sing_s[k];
			end
		end
	end

	mi3_merge #(.DW(DW)) u_merge (
		.clk          (clk),
		.en           (en[NS-1]),
		.quo          (quo),
		.neg          (neg_s[DIV_STEPS]),
		.det          (det_s[DIV_STEPS]),
		.singular     (sing_s[DIV_STEPS]),
		.inv          (inv),
		.determinant  (determinant),
		.singular_out (singular)
	);

	assign result_valid = vld_q[NS-1];
	assign inv00 = inv[0];
	assign inv01 = inv[1];
	assign inv02 = inv[2];
	assign inv10 = inv[3];
	assign inv11 = inv[4];
	assign inv12 = inv[5];
	assign inv20 = inv[6];
	assign inv21 = inv[7];
	assign inv22 = inv[8];

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> item_ready)
		else $error("input stalled while output drains");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && singular |-> determinant == '0 && inv00 == '0 && inv22 == '0)
		else $error("singular word carries nonzero fields");

	a_det_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !singular && ELEMENT_BITS <= 16 |-> determinant != '0)
		else $error("zero determinant without singular flag");

endmodule
